[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  // Field widths of the command and result channels.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned CELL_W  = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = COLOR_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 1'd1;

  // Default screen geometry.
  localparam int unsigned DEF_COLUMNS = 80;
  localparam int unsigned DEF_ROWS    = 25;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0]  CLEAR_CELL   = 16'h0F00;
  localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0000;
  localparam logic [COLOR_W-1:0] TEXT_RESET   = 4'd7;
  localparam logic [COLOR_W-1:0] BACK_RESET   = 4'd0;

  // What a print request does to the screen beyond the cursor move.
  typedef struct packed {
    logic scroll;
    logic store;
  } print_flags_t;

endpackage

[rtl/core/tcw_if.sv]
interface tcw_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CMD_W-1:0]    command;
  logic [tcw_pkg::COL_W-1:0]    column;
  logic [tcw_pkg::ROW_W-1:0]    row;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, command, column, row, char_code, input ready);
  modport sink   (input valid, command, column, row, char_code, output ready);
endinterface

interface tcw_res_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::IDX_W-1:0]    cursor_index;
  logic                         scrolled;

  modport source (output valid, cursor_col, cursor_row, cursor_index, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_index, scrolled,
                  output ready);
endinterface

[rtl/core/tcw_ram.sv]
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tcw_cursor.sv]
module tcw_cursor #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS,
  localparam int unsigned CW = $clog2(COLUMNS),
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned IW = $clog2(COLUMNS * ROWS)
) (
  input  logic [tcw_pkg::CMD_W-1:0]  command_i,
  input  logic [tcw_pkg::COL_W-1:0]  column_i,
  input  logic [tcw_pkg::ROW_W-1:0]  row_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [CW-1:0]              cur_col_i,
  input  logic [RW-1:0]              cur_row_i,
  output logic [CW-1:0]              nxt_col_o,
  output logic [RW-1:0]              nxt_row_o,
  output logic [IW-1:0]              put_addr_o,
  output tcw_pkg::print_flags_t      flags_o
);

  logic          newline;
  logic [CW:0]   col_inc;
  logic          wrap;
  logic          bottom;
  logic [RW-1:0] put_row;

  assign newline = (char_code_i == tcw_pkg::NEWLINE_CODE);
  assign col_inc = {1'b0, cur_col_i} + (CW + 1)'(1);
  assign wrap    = newline || (col_inc >= (CW + 1)'(COLUMNS));
  assign bottom  = (cur_row_i == RW'(ROWS - 1));

  // A wrap on the bottom row scrolls; the character then lands one row up.
  assign put_row    = (wrap && bottom) ? RW'(ROWS - 2) : cur_row_i;
  assign put_addr_o = IW'(put_row) * IW'(COLUMNS) + IW'(cur_col_i);

  always_comb begin
    nxt_col_o     = cur_col_i;
    nxt_row_o     = cur_row_i;
    flags_o       = '0;
    unique case (command_i)
      tcw_pkg::CMD_PRINT: begin
        nxt_col_o      = wrap ? '0 : col_inc[CW-1:0];
        nxt_row_o      = (wrap && !bottom) ? cur_row_i + RW'(1) : cur_row_i;
        flags_o.scroll = wrap && bottom;
        flags_o.store  = !newline;
      end
      tcw_pkg::CMD_CLEAR: begin
        nxt_col_o = '0;
        nxt_row_o = '0;
      end
      tcw_pkg::CMD_MOVE: begin
        nxt_col_o = (int'(column_i) > int'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(column_i);
        nxt_row_o = (int'(row_i) > int'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(row_i);
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/text_console_writer_unit.sv]
// Text console writer: a screen of attributed character cells in one
// synchronous RAM (COLUMNS * ROWS words of 16 bits) plus a cursor.
//
// Requests arrive on cmd_i (print, clear and home, move cursor); every
// request produces exactly one result on res_o with the new cursor, its
// linear index and a scroll flag. The colour registers are written through
// the cfg_* port while the block is idle; the user must keep to this, as the block itself does not enforce it.
//
// Timing: move, unused codes and prints that do not scroll are done in the
// accepting cycle; the result is loaded into the output register at the accepting edge.
// A clear sweeps the cell RAM one word a cycle.
// A scrolling print copies COLUMNS * (ROWS - 1) words through the RAM's
// single read and write port (one word a cycle, then draining the read
// pipeline), zeroes the last row and then stores the character; a newline
// stores nothing.
//
// After reset the block runs a clearing pass over all cells with
// cmd_i.ready low; no result is produced for it. A stalled receiver holds
// the result in the output register; a new request is taken while the block is idle
// and that register is free or is being emptied in the same cycle.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcw_cmd_if.sink                        cmd_i,
  tcw_res_if.source                      res_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned IW    = $clog2(CELLS);
  localparam int unsigned NW    = $clog2(CELLS + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] dst_q, dst_d;
  logic          res_pend_q, res_pend_d;
  logic          store_q, store_d;
  logic [IW-1:0] put_addr_q, put_addr_d;
  logic [tcw_pkg::CELL_W-1:0] put_data_q, put_data_d;

  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [tcw_pkg::COLOR_W-1:0] text_q, back_q;

  logic                        out_valid_q, out_valid_d;
  logic [tcw_pkg::COL_W-1:0]   out_col_q, out_col_d;
  logic [tcw_pkg::ROW_W-1:0]   out_row_q, out_row_d;
  logic [tcw_pkg::IDX_W-1:0]   out_idx_q, out_idx_d;
  logic                        out_scr_q, out_scr_d;

  logic [CW-1:0]         nxt_col;
  logic [RW-1:0]         nxt_row;
  logic [IW-1:0]         put_addr;
  tcw_pkg::print_flags_t flags;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [IW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic          accept;
  logic          out_free;
  logic [CW-1:0] sel_col;
  logic [RW-1:0] sel_row;
  logic          load_res;
  logic          load_scr;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .command_i   (cmd_i.command),
    .column_i    (cmd_i.column),
    .row_i       (cmd_i.row),
    .char_code_i (cmd_i.char_code),
    .cur_col_i   (cur_col_q),
    .cur_row_i   (cur_row_q),
    .nxt_col_o   (nxt_col),
    .nxt_row_o   (nxt_row),
    .put_addr_o  (put_addr),
    .flags_o     (flags)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register is free when empty or being emptied this cycle.
  assign out_free    = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Quick requests report the freshly computed cursor, long ones the
  // cursor registers that were updated when the request was taken.
  assign sel_col = (state_q == ST_IDLE) ? nxt_col : cur_col_q;
  assign sel_row = (state_q == ST_IDLE) ? nxt_row : cur_row_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    dst_d      = dst_q;
    res_pend_d = res_pend_q;
    store_d    = store_q;
    put_addr_d = put_addr_q;
    put_data_d = put_data_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    ram_we     = 1'b0;
    ram_waddr  = put_addr;
    ram_wdata  = {back_q, text_q, cmd_i.char_code};
    ram_raddr  = cnt_q[IW-1:0];
    load_res   = 1'b0;
    load_scr   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cur_col_d = nxt_col;
          cur_row_d = nxt_row;
          if (cmd_i.command == tcw_pkg::CMD_CLEAR) begin
            state_d    = ST_CLEAR;
            cnt_d      = '0;
            res_pend_d = 1'b1;
          end else if ((cmd_i.command == tcw_pkg::CMD_PRINT) && flags.scroll) begin
            state_d    = ST_COPY;
            cnt_d      = NW'(COLUMNS);
            res_pend_d = 1'b1;
            store_d    = flags.store;
            put_addr_d = put_addr;
            put_data_d = {back_q, text_q, cmd_i.char_code};
          end else begin
            // Print without scroll, move or unused code: done this cycle.
            ram_we   = (cmd_i.command == tcw_pkg::CMD_PRINT) && flags.store;
            load_res = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IW-1:0];
        ram_wdata = tcw_pkg::CLEAR_CELL;
        cnt_d     = cnt_q + NW'(1);
        if (cnt_q == NW'(CELLS - 1)) begin
          state_d    = ST_IDLE;
          load_res   = res_pend_q;
          res_pend_d = 1'b0;
        end
      end
      ST_COPY: begin
        // Read one row ahead; the write trails the read by the RAM latency.
        if (cnt_q != NW'(CELLS)) begin
          cnt_d  = cnt_q + NW'(1);
          pend_d = 1'b1;
          dst_d  = IW'(cnt_q - NW'(COLUMNS));
        end
        ram_we    = pend_q;
        ram_waddr = dst_q;
        ram_wdata = ram_rdata;
        if ((cnt_q == NW'(CELLS)) && !pend_q) begin
          state_d = ST_ZERO;
          cnt_d   = NW'(CELLS - COLUMNS);
        end
      end
      ST_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IW-1:0];
        ram_wdata = tcw_pkg::BLANK_CELL;
        cnt_d     = cnt_q + NW'(1);
        if (cnt_q == NW'(CELLS - 1)) begin
          if (store_q) begin
            state_d = ST_PUT;
          end else begin
            state_d    = ST_IDLE;
            load_res   = 1'b1;
            load_scr   = 1'b1;
            res_pend_d = 1'b0;
          end
        end
      end
      ST_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = put_addr_q;
        ram_wdata  = put_data_q;
        state_d    = ST_IDLE;
        load_res   = 1'b1;
        load_scr   = 1'b1;
        res_pend_d = 1'b0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_idx_d   = out_idx_q;
    out_scr_d   = out_scr_q;
    if (load_res) begin
      out_valid_d = 1'b1;
      out_col_d   = tcw_pkg::COL_W'(sel_col);
      out_row_d   = tcw_pkg::ROW_W'(sel_row);
      out_idx_d   = tcw_pkg::IDX_W'(32'(sel_row) * 32'(COLUMNS) + 32'(sel_col));
      out_scr_d   = load_scr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      res_pend_q  <= 1'b0;
      store_q     <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      text_q      <= tcw_pkg::TEXT_RESET;
      back_q      <= tcw_pkg::BACK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      res_pend_q  <= res_pend_d;
      store_q     <= store_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcw_pkg::CFG_TEXT_COLOR: text_q <= cfg_data_i;
          tcw_pkg::CFG_BACK_COLOR: back_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q      <= dst_d;
    put_addr_q <= put_addr_d;
    put_data_q <= put_data_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_idx_q  <= out_idx_d;
    out_scr_q  <= out_scr_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.cursor_col   = out_col_q;
  assign res_o.cursor_row   = out_row_q;
  assign res_o.cursor_index = out_idx_q;
  assign res_o.scrolled     = out_scr_q;

endmodule
